>>> sv/ofip_pkg.sv
// ----------------------------------------------------------------------------
// ofip_pkg
// Shared types and constants of the OBJ face line parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ofip_pkg;

  // Width of an index accumulator; indices saturate at 2^INDEX_BITS-1.
  localparam int unsigned INDEX_BITS = 24;
  // Width of each index field on the result stream.
  localparam int unsigned OUT_BITS   = 24;
  // Three vertices with position, texture and normal index each.
  localparam int unsigned NUM_SLOTS  = 9;

  // Byte queue between classifier and parser; depth must be a power of two.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Result stream: nine indices, then the malformed flag, padded to bytes.
  localparam int unsigned OUT_PAYLOAD_W = NUM_SLOTS * OUT_BITS + 1;
  localparam int unsigned OUT_TDATA_W   = ((OUT_PAYLOAD_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W     = OUT_TDATA_W - OUT_PAYLOAD_W;

  // ASCII codes
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_F       = 8'h66;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // Character class of one text byte
  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_SLASH,
    CLS_HASH,
    CLS_F,
    CLS_SPACE,
    CLS_NEWLINE,
    CLS_OTHER
  } ofip_cls_e;

  // Classified byte as it travels through the queue
  typedef struct packed {
    ofip_cls_e  cls;
    logic [3:0] digit;
    logic       last;
  } ofip_item_t;

  // One face result
  typedef struct packed {
    logic                                malformed;
    logic [NUM_SLOTS-1:0][OUT_BITS-1:0] idx;
  } ofip_face_t;

endpackage : ofip_pkg

`default_nettype wire

>>> sv/ofip_front.sv
// ----------------------------------------------------------------------------
// ofip_front
// Input stage: accept text bytes, classify them and hand them to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ofip_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         text_byte_i,
  input  wire logic               end_of_text_i,
  output logic                    push_o,
  output ofip_pkg::ofip_item_t    item_o,
  input  wire logic               q_ready_i
);
  import ofip_pkg::*;

  logic       valid_q, valid_d;
  ofip_item_t item_q, item_d;
  logic       take;

  function automatic ofip_item_t classify(logic [7:0] ch, logic last);
    ofip_item_t it;
    logic [7:0] diff;
    diff     = ch - CH_ZERO;
    it.digit = diff[3:0];
    it.last  = last;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      it.cls = CLS_DIGIT;
    end else if (ch == CH_SLASH) begin
      it.cls = CLS_SLASH;
    end else if (ch == CH_HASH) begin
      it.cls = CLS_HASH;
    end else if (ch == CH_F) begin
      it.cls = CLS_F;
    end else if (ch == CH_SPACE) begin
      it.cls = CLS_SPACE;
    end else if (ch == CH_NEWLINE) begin
      it.cls = CLS_NEWLINE;
    end else begin
      it.cls = CLS_OTHER;
    end
    return it;
  endfunction

  assign in_ready_o = !valid_q || q_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign push_o     = valid_q && q_ready_i;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (take) begin
      valid_d = 1'b1;
      item_d  = classify(text_byte_i, end_of_text_i);
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule : ofip_front

`default_nettype wire

>>> sv/ofip_fifo.sv
// ----------------------------------------------------------------------------
// ofip_fifo
// Short queue of classified bytes between the classifier and the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module ofip_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire ofip_pkg::ofip_item_t item_i,
  output logic                    ready_o,
  output logic                    valid_o,
  output ofip_pkg::ofip_item_t    item_o,
  input  wire logic               pop_i
);
  import ofip_pkg::*;

  ofip_item_t            mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;

  assign ready_o = cnt_q != FIFO_CNT_W'(FIFO_DEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // Occupancy stays within the depth, and the pointers agree with it.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("pop from empty queue");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != FIFO_CNT_W'(FIFO_DEPTH)) |->
      (FIFO_PTR_W'(wr_ptr_q - rd_ptr_q) == cnt_q[FIFO_PTR_W-1:0]))
    else $error("queue pointers disagree with count");

endmodule : ofip_fifo

`default_nettype wire

>>> sv/ofip_back.sv
// ----------------------------------------------------------------------------
// ofip_back
// Parser: line state machine, index accumulation and the face result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ofip_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  input  wire ofip_pkg::ofip_item_t item_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output ofip_pkg::ofip_face_t    face_o
);
  import ofip_pkg::*;

  typedef enum logic [2:0] {
    PH_LINE_START,
    PH_SKIP_LINE,
    PH_SAW_F,
    PH_FACE_GAP,
    PH_FACE_FIELD,
    PH_FACE_TAIL
  } phase_e;

  phase_e                phase_q, phase_d, p1;
  logic [1:0]            vert_q, vert_d, vert1;
  logic [1:0]            comp_q, comp_d, comp1;
  logic [INDEX_BITS-1:0] acc_q, acc_d, acc1, acc_sat, cm_data;
  logic                  seen_q, seen_d, seen1;
  logic                  err_q, err_d, err_e;
  logic [INDEX_BITS-1:0] face_q [NUM_SLOTS];
  logic [INDEX_BITS-1:0] face_d [NUM_SLOTS];
  logic [INDEX_BITS-1:0] face_e [NUM_SLOTS];
  logic                  clr, cm, nl_emit, do_emit, emit_cm, face_phase1;
  logic [3:0]            cm_slot;
  logic                  out_valid_q;
  ofip_face_t            out_q, out_d;

  function automatic logic [3:0] slot_of(logic [1:0] v, logic [1:0] c);
    return {1'b0, v, 1'b0} + {2'b00, v} + {2'b00, c};
  endfunction

  // acc*10 + digit, saturating at the all-ones index
  function automatic logic [INDEX_BITS-1:0] accumulate(logic [INDEX_BITS-1:0] a,
                                                         logic [3:0] d);
    logic [INDEX_BITS+3:0] ext;
    logic [INDEX_BITS+3:0] sum;
    ext = {4'b0000, a};
    sum = (ext << 3) + (ext << 1) + {{INDEX_BITS{1'b0}}, d};
    if (sum[INDEX_BITS+3:INDEX_BITS] != 4'b0000) begin
      return {INDEX_BITS{1'b1}};
    end
    return sum[INDEX_BITS-1:0];
  endfunction

  function automatic logic [OUT_BITS-1:0] to_out(logic [INDEX_BITS-1:0] v);
    logic [OUT_BITS+INDEX_BITS-1:0] tmp;
    tmp = {{OUT_BITS{1'b0}}, v};
    return tmp[OUT_BITS-1:0];
  endfunction

  assign pop_o       = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign face_o      = out_q;
  assign acc_sat     = accumulate(acc_q, item_i.digit);

  always_comb begin
    p1      = phase_q;
    vert1   = vert_q;
    comp1   = comp_q;
    acc1    = acc_q;
    seen1   = seen_q;
    err_e   = err_q;
    clr     = 1'b0;
    cm      = 1'b0;
    cm_slot = slot_of(vert_q, comp_q);
    cm_data = acc_q;
    nl_emit = 1'b0;
    emit_cm = 1'b0;

    // Process the byte itself.
    case (phase_q)
      PH_LINE_START: begin
        if (item_i.cls == CLS_F) begin
          p1 = PH_SAW_F;
        end else if (item_i.cls != CLS_SPACE && item_i.cls != CLS_NEWLINE) begin
          p1 = PH_SKIP_LINE;
        end
      end
      PH_SAW_F: begin
        if (item_i.cls == CLS_SPACE) begin
          clr   = 1'b1;
          vert1 = '0;
          comp1 = '0;
          acc1  = '0;
          seen1 = 1'b0;
          err_e = 1'b0;
          p1    = PH_FACE_GAP;
        end else if (item_i.cls == CLS_NEWLINE) begin
          p1 = PH_LINE_START;
        end else begin
          p1 = PH_SKIP_LINE;
        end
      end
      PH_FACE_GAP: begin
        if (item_i.cls == CLS_NEWLINE) begin
          nl_emit = 1'b1;
        end else if (item_i.cls == CLS_DIGIT) begin
          acc1  = {{(INDEX_BITS-4){1'b0}}, item_i.digit};
          seen1 = 1'b1;
          p1    = PH_FACE_FIELD;
        end else if (item_i.cls != CLS_SPACE) begin
          err_e = 1'b1;
          p1    = PH_FACE_TAIL;
        end
      end
      PH_FACE_FIELD: begin
        case (item_i.cls)
          CLS_NEWLINE: nl_emit = 1'b1;
          CLS_DIGIT: begin
            acc1  = acc_sat;
            seen1 = 1'b1;
          end
          CLS_SLASH: begin
            if (comp_q == 2'd2) begin
              err_e = 1'b1;
              p1    = PH_FACE_TAIL;
            end else begin
              cm    = seen_q;
              acc1  = '0;
              seen1 = 1'b0;
              comp1 = comp_q + 2'd1;
            end
          end
          CLS_SPACE: begin
            if (seen_q) begin
              cm    = 1'b1;
              acc1  = '0;
              seen1 = 1'b0;
              vert1 = vert_q + 2'd1;
              comp1 = '0;
              p1    = (vert_q == 2'd2) ? PH_FACE_TAIL : PH_FACE_GAP;
            end
          end
          default: begin
            err_e = 1'b1;
            p1    = PH_FACE_TAIL;
          end
        endcase
      end
      PH_FACE_TAIL: begin
        if (item_i.cls == CLS_NEWLINE) begin
          nl_emit = 1'b1;
        end
      end
      PH_SKIP_LINE: begin
        if (item_i.cls == CLS_NEWLINE) begin
          p1 = PH_LINE_START;
        end
      end
      default: p1 = PH_LINE_START;
    endcase

    // Close the face on its newline, or on end of text while a face is open.
    face_phase1 = (p1 == PH_FACE_GAP) || (p1 == PH_FACE_FIELD) || (p1 == PH_FACE_TAIL);
    do_emit     = face_phase1 && (nl_emit || item_i.last);
    if (do_emit) begin
      if (p1 == PH_FACE_GAP) begin
        err_e = 1'b1;
      end
      if (p1 == PH_FACE_FIELD) begin
        if (vert1 < 2'd2) begin
          err_e = 1'b1;
        end
        if (seen1) begin
          emit_cm = 1'b1;
          cm      = 1'b1;
          cm_slot = slot_of(vert1, comp1);
          cm_data = acc1;
        end
      end
    end

    for (int i = 0; i < NUM_SLOTS; i++) begin
      face_e[i] = (cm && cm_slot == 4'(i)) ? cm_data : face_q[i];
      face_d[i] = clr ? '0 : face_e[i];
    end

    phase_d = (do_emit || item_i.last) ? PH_LINE_START : p1;
    vert_d  = vert1;
    comp_d  = comp1;
    acc_d   = emit_cm ? '0 : acc1;
    seen_d  = emit_cm ? 1'b0 : seen1;
    err_d   = err_e;

    out_d.malformed = err_e;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      out_d.idx[i] = to_out(face_d[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LINE_START;
      vert_q      <= '0;
      comp_q      <= '0;
      acc_q       <= '0;
      seen_q      <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        face_q[i] <= '0;
      end
    end else begin
      if (pop_o) begin
        phase_q <= phase_d;
        vert_q  <= vert_d;
        comp_q  <= comp_d;
        acc_q   <= acc_d;
        seen_q  <= seen_d;
        err_q   <= err_d;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          face_q[i] <= face_d[i];
        end
      end
      if (pop_o && do_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && do_emit) begin
      out_q <= out_d;
    end
  end

  // End of text always leaves the parser at line start.
  a_eot_line_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && item_i.last |=> phase_q == PH_LINE_START)
    else $error("parser not at line start after end of text");

  // Inside a face the slot stays within three vertices of three components.
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FACE_GAP || phase_q == PH_FACE_FIELD) |->
      (vert_q != 2'd3 && comp_q != 2'd3))
    else $error("face slot out of range");

  // A new result is only loaded while the previous one is gone or leaving.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && do_emit) |-> (!out_valid_q || out_ready_i))
    else $error("face result overwritten before delivery");

endmodule : ofip_back

`default_nettype wire

>>> sv/obj_face_index_parser_unit.sv
// ----------------------------------------------------------------------------
// obj_face_index_parser_unit
// Streaming parser for triangle face lines of OBJ text, one byte per item.
// ----------------------------------------------------------------------------
// Throughput: one text byte per cycle while the result side keeps taking.
// Path: the byte that closes a face (its newline or end-of-text byte) moves
//   from the classifier register into the queue; when the parser takes it
//   from the queue, it is parsed and loads the parser result register.
// Reset: parser at line start, queue empty, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module obj_face_index_parser_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Text side
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  input  wire logic [7:0]                         s_axis_tdata_i,   // [7:0] text_byte
  input  wire logic                               s_axis_tlast_i,   // end_of_text
  // Face side
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // From bit 0 up, 24 bits each: vertex_index_1, texture_index_1,
  // normal_index_1, vertex_index_2, texture_index_2, normal_index_2,
  // vertex_index_3, texture_index_3, normal_index_3; then [216] malformed,
  // [223:217] zero
  output logic [ofip_pkg::OUT_TDATA_W-1:0]        m_axis_tdata_o
);
  import ofip_pkg::*;

  // Front to queue
  logic       push;
  ofip_item_t front_item;
  logic       q_ready;

  // Queue to parser
  logic       q_valid;
  ofip_item_t q_item;
  logic       pop;

  ofip_face_t face;

  // Classify each byte (digit, separator, space, newline, ...) and hold it
  // until the queue has room.
  ofip_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .text_byte_i   (s_axis_tdata_i),
    .end_of_text_i (s_axis_tlast_i),
    .push_o        (push),
    .item_o        (front_item),
    .q_ready_i     (q_ready)
  );

  // Decouple intake from the parser so a stalled result does not stop the
  // text stream at once.
  ofip_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (pop)
  );

  // Walk the line state machine, accumulate decimal indices into the nine
  // face slots and register one result per closed face line.
  ofip_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .item_i      (q_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .face_o      (face)
  );

  // Pack: indices from the lowest bits up, then the malformed flag, zero pad.
  assign m_axis_tdata_o = {{OUT_PAD_W{1'b0}}, face.malformed, face.idx};

endmodule : obj_face_index_parser_unit

`default_nettype wire

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the OBJ face line parser. Feeds OBJ text byte by
// byte (directed lines first, then random face, comment, junk and noise
// lines), predicts every face result from the accepted bytes, and compares
// each result on the face stream slot by slot under random sender bursts and
// receiver stalls.
// ----------------------------------------------------------------------------

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ofip_pkg::*;

  // Stop the random text once this many bytes of face lines went out.
  localparam int unsigned FACE_BYTES_TARGET = 1250;
  // Cycles without any accepted item before the run is declared hung.
  localparam int unsigned IDLE_LIMIT        = 4000;
  // Length of the one long result-side hold-off.
  localparam int unsigned LONG_HOLD_CYCLES  = 400;
  // Quiet cycles after the last result.
  localparam int unsigned TAIL_CYCLES       = 12;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_TOP = 8'hFF;

  // Where the parser stands within the current line.
  typedef enum logic [2:0] {
    LP_START,
    LP_SKIP,
    LP_SAW_F,
    LP_GAP,
    LP_FIELD,
    LP_TAIL
  } line_phase_e;

  // --------------------------------------------------------------------------
  // Face ledger: tracks the line state from the accepted text bytes, keeps
  // the faces that must come out, and matches the faces that do come out.
  // --------------------------------------------------------------------------
  class face_ledger;
    line_phase_e phase;
    int unsigned slot;
    logic [63:0] acc;
    bit          digit_seen;
    logic [63:0] idx [NUM_SLOTS];
    bit          bad;
    ofip_face_t  faces_due [$];
    int unsigned errors;
    int unsigned faces_matched;
    int unsigned faces_malformed;

    function new();
      phase           = LP_START;
      slot            = 0;
      acc             = '0;
      digit_seen      = 1'b0;
      bad             = 1'b0;
      errors          = 0;
      faces_matched   = 0;
      faces_malformed = 0;
      foreach (idx[j]) idx[j] = '0;
    endfunction

    function int unsigned pending();
      return faces_due.size();
    endfunction

    // Store the number being built into the current slot, if it has digits.
    function void store_number();
      if (digit_seen && slot < NUM_SLOTS) idx[slot] = acc;
      acc        = '0;
      digit_seen = 1'b0;
    endfunction

    function void flag_bad();
      bad   = 1'b1;
      phase = LP_TAIL;
    endfunction

    // Close the open face line and queue the face it yields.
    function void close_face();
      ofip_face_t f;
      int         j;
      if (phase == LP_GAP) begin
        bad = 1'b1;
      end else if (phase == LP_FIELD) begin
        // fewer than three position indices seen: truncated
        if (slot < 6) bad = 1'b1;
        store_number();
      end
      for (j = 0; j < NUM_SLOTS; j++) f.idx[j] = idx[j][OUT_BITS-1:0];
      f.malformed = bad;
      faces_due.push_back(f);
      phase = LP_START;
    endfunction

    function void take_byte(input logic [7:0] ch, input logic last);
      bit          is_digit;
      bit          emitted;
      logic [63:0] grown;
      logic [63:0] index_top;
      is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
      emitted   = 1'b0;
      index_top = (64'd1 << INDEX_BITS) - 64'd1;
      case (phase)
        LP_START: begin
          if (ch == CH_F) phase = LP_SAW_F;
          else if (ch != CH_SPACE && ch != CH_NEWLINE) phase = LP_SKIP;
        end
        LP_SAW_F: begin
          if (ch == CH_SPACE) begin
            foreach (idx[j]) idx[j] = '0;
            slot       = 0;
            acc        = '0;
            digit_seen = 1'b0;
            bad        = 1'b0;
            phase      = LP_GAP;
          end else if (ch == CH_NEWLINE) begin
            phase = LP_START;
          end else begin
            phase = LP_SKIP;
          end
        end
        LP_GAP: begin
          if (ch == CH_NEWLINE) begin
            close_face();
            emitted = 1'b1;
          end else if (is_digit) begin
            acc        = 64'(ch - CH_ZERO);
            digit_seen = 1'b1;
            phase      = LP_FIELD;
          end else if (ch != CH_SPACE) begin
            flag_bad();
          end
        end
        LP_FIELD: begin
          if (ch == CH_NEWLINE) begin
            close_face();
            emitted = 1'b1;
          end else if (is_digit) begin
            grown      = acc * 64'd10 + 64'(ch - CH_ZERO);
            acc        = (grown > index_top) ? index_top : grown;
            digit_seen = 1'b1;
          end else if (ch == CH_SLASH) begin
            if (slot % 3 == 2) begin
              flag_bad();
            end else begin
              store_number();
              slot++;
            end
          end else if (ch == CH_SPACE) begin
            // a space after digits ends the vertex; one right after '/' is skipped
            if (digit_seen) begin
              store_number();
              slot  = (slot / 3 + 1) * 3;
              phase = (slot >= NUM_SLOTS) ? LP_TAIL : LP_GAP;
            end
          end else begin
            flag_bad();
          end
        end
        LP_TAIL: begin
          if (ch == CH_NEWLINE) begin
            close_face();
            emitted = 1'b1;
          end
        end
        default: begin
          if (ch == CH_NEWLINE) phase = LP_START;
        end
      endcase
      if (last) begin
        if (!emitted && (phase == LP_GAP || phase == LP_FIELD || phase == LP_TAIL))
          close_face();
        phase = LP_START;
      end
    endfunction

    function void match_face(input logic [OUT_TDATA_W-1:0] tdata);
      ofip_face_t want;
      ofip_face_t got;
      string      label;
      int         k;
      if (faces_due.size() == 0) begin
        errors++;
        $display("t=%0t face with none expected: expected nothing, actual %h", $time, tdata);
        return;
      end
      want = faces_due.pop_front();
      got  = tdata[OUT_PAYLOAD_W-1:0];
      faces_matched++;
      if (want.malformed) faces_malformed++;
      for (k = 0; k < NUM_SLOTS; k++) begin
        if (got.idx[k] !== want.idx[k]) begin
          case (k % 3)
            0:       label = "vertex";
            1:       label = "texture";
            default: label = "normal";
          endcase
          errors++;
          $display("t=%0t face %0d %s_index_%0d: expected %0d, actual %0d", $time,
                   faces_matched, label, k / 3 + 1, want.idx[k], got.idx[k]);
        end
      end
      if (got.malformed !== want.malformed) begin
        errors++;
        $display("t=%0t face %0d malformed: expected %0b, actual %0b", $time,
                 faces_matched, want.malformed, got.malformed);
      end
      if (tdata[OUT_TDATA_W-1:OUT_PAYLOAD_W] !== '0) begin
        errors++;
        $display("t=%0t face %0d pad bits: expected 0, actual %h", $time,
                 faces_matched, tdata[OUT_TDATA_W-1:OUT_PAYLOAD_W]);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [7:0]             s_axis_tdata_i  = 8'h00;  // [7:0] text_byte
  logic                   s_axis_tlast_i  = 1'b0;   // end_of_text
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  // nine 24-bit indices from bit 0 up, then malformed, then zero padding
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  obj_face_index_parser_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  face_ledger  ledger;
  logic [7:0]  text_q [$];       // bytes of the line being built
  int unsigned burst_left  = 0;  // items left in the current sender burst
  int unsigned bytes_taken = 0;
  int unsigned text_ends   = 0;
  int unsigned idle_cycles = 0;

  // Long hold-off requests from the stimulus, served by the receiver process.
  int unsigned holds_asked     = 0;
  int unsigned holds_served    = 0;
  int unsigned hold_left       = 0;
  int unsigned ready_mode      = 0;
  int unsigned ready_mode_left = 0;

  // --------------------------------------------------------------------------
  // Monitor and watchdog: sample both handshakes at the rising edge, before
  // any driven value of this edge lands.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        ledger.take_byte(s_axis_tdata_i, s_axis_tlast_i);
        bytes_taken++;
        if (s_axis_tlast_i) text_ends++;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) ledger.match_face(m_axis_tdata_o);
      // reset the hang count on any accepted item, else advance it
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("t=%0t no item accepted for %0d cycles", $time, idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: switch between stall patterns chosen at random; on a request,
  // hold tready low for one long stretch so the queue fills up.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = LONG_HOLD_CYCLES;
      m_axis_tready_i <= 1'b0;
    end else begin
      if (ready_mode_left == 0) begin
        ready_mode      = $urandom_range(0, 3);
        ready_mode_left = $urandom_range(16, 128);
      end else begin
        ready_mode_left--;
      end
      case (ready_mode)
        0:       m_axis_tready_i <= 1'b1;                          // no stalls
        1:       m_axis_tready_i <= 1'($urandom_range(0, 1));
        2:       m_axis_tready_i <= ($urandom_range(0, 7) != 0);  // rare stalls
        default: m_axis_tready_i <= ($urandom_range(0, 5) == 0);  // mostly stalled
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sender: offer one byte, in bursts of random length with random gaps.
  // Return at the edge that accepts it.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] ch, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= ch;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Send the built line; mark its last byte as end of text if asked.
  task automatic send_text(input bit end_text);
    int k;
    for (k = 0; k < text_q.size(); k++)
      send_byte(text_q[k], end_text && (k == text_q.size() - 1));
    text_q.delete();
  endtask

  // Stop offering and hold until every queued face has come out.
  task automatic wait_faces_done();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (ledger.pending() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Line builders
  // --------------------------------------------------------------------------
  function automatic void add_str(input string s);
    int k;
    for (k = 0; k < s.len(); k++) text_q.push_back(8'(s[k]));
  endfunction

  function automatic void add_spaces(input int unsigned n);
    repeat (n) text_q.push_back(CH_SPACE);
  endfunction

  // Mostly short indices; now and then long ones around the saturation point.
  function automatic void add_num();
    int unsigned n;
    case ($urandom_range(0, 11))
      0:       n = $urandom_range(7, 10);
      1:       n = 8;
      2:       n = 0;
      default: n = $urandom_range(1, 3);
    endcase
    if (n == 0) begin
      add_str(($urandom_range(0, 1) == 0) ? "16777215" : "16777216");
    end else begin
      repeat (n) text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end
  endfunction

  // Drop in one or two spaces after a slash now and then.
  function automatic void add_slash();
    text_q.push_back(CH_SLASH);
    if ($urandom_range(0, 4) == 0) add_spaces($urandom_range(1, 2));
  endfunction

  // One vertex spec: v, v/vt, v//vn or v/vt/vn; optionally a third slash.
  function automatic void add_vertex(input bit third_slash);
    int unsigned form;
    form = third_slash ? 3 : $urandom_range(0, 3);
    add_num();
    if (form != 0) begin
      add_slash();
      if (form != 2) add_num();
      if (form >= 2) begin
        add_slash();
        add_num();
      end
    end
    if (third_slash) begin
      text_q.push_back(CH_SLASH);
      add_num();
    end
  endfunction

  // Face line, clean or with one flaw: truncation, a stray byte, a slash
  // where a vertex should start, a carriage return, or a third slash.
  function automatic void add_face_line(input bit broken);
    int unsigned flaw;
    int unsigned flaw_vertex;
    int unsigned n_vert;
    int unsigned body_start;
    int unsigned k;
    flaw        = broken ? $urandom_range(1, 5) : 0;
    flaw_vertex = $urandom_range(0, 2);
    if ($urandom_range(0, 5) == 0) add_spaces($urandom_range(1, 3));
    text_q.push_back(CH_F);
    add_spaces($urandom_range(1, 2));
    body_start = text_q.size();
    n_vert = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 5) : 3;
    if (flaw == 1) n_vert = $urandom_range(0, 2);
    for (k = 0; k < n_vert; k++) begin
      if (k != 0) add_spaces($urandom_range(1, 3));
      if (flaw == 3 && k == flaw_vertex) text_q.push_back(CH_SLASH);
      add_vertex(flaw == 5 && k == flaw_vertex);
    end
    if ($urandom_range(0, 3) == 0) add_spaces($urandom_range(1, 2));
    if (flaw == 2)
      text_q.insert($urandom_range(body_start, text_q.size() - 1), 8'($urandom_range(0, 255)));
    if (flaw == 4) text_q.push_back(CH_CR);
    text_q.push_back(CH_NEWLINE);
  endfunction

  // Lines that hold no face: comments, empty lines, other records.
  function automatic void add_other_line();
    case ($urandom_range(0, 7))
      0:       add_str("# f 1 2 3");
      1:       begin end
      2:       add_spaces($urandom_range(1, 4));
      3:       add_str("v 1.5 -2.0 3");
      4:       add_str("vt 0.25 0.75");
      5:       text_q.push_back(CH_F);
      6:       add_str("fx 1 2 3");
      default: add_str("vn 0 1 0");
    endcase
    text_q.push_back(CH_NEWLINE);
  endfunction

  // Raw bytes over the whole range, with or without a closing newline.
  function automatic void add_noise();
    repeat ($urandom_range(1, 16)) text_q.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 1) == 0) text_q.push_back(CH_NEWLINE);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned pick;
    int unsigned face_bytes;
    bit          end_text;
    bit          hold_done;
    bit          pause_done;
    face_bytes = 0;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    ledger     = new();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: leading space, space after '/', missing texture index,
    // saturating index, extra vertex, a skipped junk line, lone 'f' at end.
    add_str(" f 1/ 2/3 4//5 99999999 7");
    text_q.push_back(CH_NEWLINE);
    text_q.push_back(CH_TOP);
    text_q.push_back(CH_NEWLINE);
    text_q.push_back(CH_F);
    send_text(1'b1);

    // Random text: mostly well-formed faces, the rest flawed faces,
    // other lines and noise.
    while (face_bytes < FACE_BYTES_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick < 12)      add_face_line(1'b0);
      else if (pick < 15) add_face_line(1'b1);
      else if (pick < 18) add_other_line();
      else                add_noise();
      if (pick < 15) face_bytes += text_q.size();
      // end the text now and then, sometimes without a closing newline
      end_text = ($urandom_range(0, 7) == 0);
      if (end_text && text_q.size() > 1 && $urandom_range(0, 1) == 1)
        void'(text_q.pop_back());
      send_text(end_text);
      if (!hold_done && face_bytes >= FACE_BYTES_TARGET / 3) begin
        holds_asked++;
        hold_done = 1'b1;
      end
      if (!pause_done && face_bytes >= 2 * FACE_BYTES_TARGET / 3) begin
        wait_faces_done();
        pause_done = 1'b1;
      end
    end

    wait_faces_done();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (ledger.pending() != 0) begin
      ledger.errors++;
      $display("t=%0t faces never delivered: expected 0 left, actual %0d", $time,
               ledger.pending());
    end
    $display("run: %0d text bytes over %0d text ends, %0d faces checked (%0d malformed)",
             bytes_taken, text_ends, ledger.faces_matched, ledger.faces_malformed);
    $display("run: one long result stall and one full drain pause, mismatches %0d",
             ledger.errors);
    if (ledger.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
sv/ofip_pkg.sv
sv/ofip_front.sv
sv/ofip_fifo.sv
sv/ofip_back.sv
sv/obj_face_index_parser_unit.sv
tb/sv/tb.sv
